// ===== hw/rtl/sed_pkg.sv =====
// sed_pkg: shared constants for the stat entry decoder
// record layout offsets, phase codes, result kinds and error codes
// no dependencies
package sed_pkg;

  localparam int unsigned OFF_W  = 17;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned LIM_W  = 9;

  // smallest size accepted: size, fixed part, three empty string lengths
  localparam logic [OFF_W-1:0] MIN_TOTAL     = OFF_W'(2 + 39 + 2 + 2 + 2);
  localparam logic [OFF_W-1:0] OFF_QID_TYPE  = OFF_W'(8);
  localparam logic [OFF_W-1:0] OFF_MODE_TOP  = OFF_W'(8 + 1 + 4 + 8 + 3);
  localparam logic [OFF_W-1:0] OFF_LENGTH    = OFF_W'(8 + 1 + 4 + 8 + 4 + 4 + 4);
  localparam logic [OFF_W-1:0] OFF_FIXED_END = OFF_W'(8 + 1 + 4 + 8 + 4 + 4 + 4 + 8);
  localparam logic [LIM_W-1:0] NAME_LIMIT_RST = LIM_W'(64);

  // record phases
  localparam logic [2:0] PH_SZ_LO  = 3'd0;
  localparam logic [2:0] PH_SZ_HI  = 3'd1;
  localparam logic [2:0] PH_FIXED  = 3'd2;
  localparam logic [2:0] PH_LEN_LO = 3'd3;
  localparam logic [2:0] PH_LEN_HI = 3'd4;
  localparam logic [2:0] PH_STR    = 3'd5;
  localparam logic [2:0] PH_TRAIL  = 3'd6;

  // result kinds
  localparam logic [1:0] KIND_NAME = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_SHORT   = 2'd0;
  localparam logic [1:0] ERR_SIZE    = 2'd1;
  localparam logic [1:0] ERR_OVERRUN = 2'd2;
  localparam logic [1:0] ERR_TRUNC   = 2'd3;

endpackage

// ===== hw/rtl/stat_entry_decoder.sv =====
// stat_entry_decoder: byte-serial decoder for packed 9P stat records
// depends on sed_pkg for layout offsets and codes
//
// Takes one stream word per clock and gives at most one result word per input
// word: a name byte, a record-complete report (length, directory flag, bytes
// consumed) or an error. Each word goes through combinational field-state logic
// into one output register, so a new word is taken every cycle while the
// output side is not stalled; input stall follows output stall only while that
// register is full. A result is valid in the cycle after its word is accepted.
// After an error the block drops words up to the next one marked last, then
// expects a new size field. Write name_limit only while idle (not enforced).
module stat_entry_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [sed_pkg::LIM_W-1:0]      cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_byte,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_kind,
  output logic [7:0]                     out_name_char,
  output logic [63:0]                    out_file_length,
  output logic                           out_dir_flag,
  output logic [sed_pkg::OFF_W-1:0]      out_consumed,
  output logic [1:0]                     out_error_code
);

  localparam int unsigned OW = sed_pkg::OFF_W;
  localparam int unsigned LW = sed_pkg::LEN_W;

  logic [sed_pkg::LIM_W-1:0] name_limit_r;
  logic [2:0]    phase_r, phase_nxt;
  logic [OW-1:0] byte_off_r, byte_off_nxt;
  logic [OW-1:0] rec_total_r, rec_total_nxt;
  logic          qid_dir_r, qid_dir_nxt;
  logic          mode_dir_r, mode_dir_nxt;
  logic [63:0]   length_r, length_nxt;
  logic [LW-1:0] str_left_r, str_left_nxt;
  logic [1:0]    str_num_r, str_num_nxt;
  logic [LW-1:0] name_sent_r, name_sent_nxt;
  logic          discard_r, discard_nxt;

  logic          out_valid_r;
  logic [1:0]    kind_r, err_code_r;
  logic [7:0]    name_char_r;
  logic [63:0]   file_len_r;
  logic          is_dir_r;
  logic [OW-1:0] consumed_r;

  logic          in_acc;
  logic          res_valid;
  logic [1:0]    res_kind, res_err;
  logic [7:0]    res_char;
  logic [63:0]   res_len;
  logic          res_dir;
  logic [OW-1:0] res_consumed;

  logic          err_hit, done, emit, clear_rec;
  logic [OW-1:0] o, off_inc;
  logic [LW-1:0] len_full, left_dec;
  logic [2:0]    sn_inc;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    phase_nxt     = phase_r;
    byte_off_nxt  = byte_off_r;
    rec_total_nxt = rec_total_r;
    qid_dir_nxt   = qid_dir_r;
    mode_dir_nxt  = mode_dir_r;
    length_nxt    = length_r;
    str_left_nxt  = str_left_r;
    str_num_nxt   = str_num_r;
    name_sent_nxt = name_sent_r;
    discard_nxt   = discard_r;
    err_hit   = 1'b0;
    res_err   = sed_pkg::ERR_SHORT;
    done      = 1'b0;
    emit      = 1'b0;
    clear_rec = 1'b0;
    o         = byte_off_r;
    off_inc   = byte_off_r + OW'(1);
    len_full  = {in_byte, str_left_r[7:0]};
    left_dec  = str_left_r - LW'(1);
    sn_inc    = {1'b0, str_num_r} + 3'd1;
    res_valid    = 1'b0;
    res_kind     = sed_pkg::KIND_NAME;
    res_char     = 8'd0;
    res_len      = 64'd0;
    res_dir      = 1'b0;
    res_consumed = '0;

    if (in_acc) begin
      if (discard_r) begin
        if (in_last) begin
          discard_nxt = 1'b0;
        end
      end else begin
        unique case (phase_r)
          sed_pkg::PH_SZ_LO: begin
            o             = '0;
            off_inc       = OW'(1);
            rec_total_nxt = {{(OW-8){1'b0}}, in_byte};
            qid_dir_nxt   = 1'b0;
            mode_dir_nxt  = 1'b0;
            length_nxt    = 64'd0;
            str_left_nxt  = '0;
            str_num_nxt   = '0;
            name_sent_nxt = '0;
            phase_nxt     = sed_pkg::PH_SZ_HI;
            if (in_last) begin
              err_hit = 1'b1;
              res_err = sed_pkg::ERR_SHORT;
            end
          end
          sed_pkg::PH_SZ_HI: begin
            rec_total_nxt = {1'b0, in_byte, rec_total_r[7:0]} + OW'(2);
            phase_nxt     = sed_pkg::PH_FIXED;
            if (rec_total_nxt < sed_pkg::MIN_TOTAL) begin
              err_hit = 1'b1;
              res_err = sed_pkg::ERR_SIZE;
            end
          end
          sed_pkg::PH_FIXED: begin
            if (o == sed_pkg::OFF_QID_TYPE) begin
              qid_dir_nxt = in_byte[7];
            end
            if (o == sed_pkg::OFF_MODE_TOP) begin
              mode_dir_nxt = in_byte[7];
            end
            // little-endian length, one lane per offset
            for (int i = 0; i < 8; i++) begin
              if (o == sed_pkg::OFF_LENGTH + OW'(i)) begin
                length_nxt[8*i +: 8] = in_byte;
              end
            end
            if (off_inc >= sed_pkg::OFF_FIXED_END) begin
              str_num_nxt = '0;
              if ({1'b0, off_inc} + 18'd2 > {1'b0, rec_total_r}) begin
                err_hit = 1'b1;
                res_err = sed_pkg::ERR_OVERRUN;
              end else begin
                phase_nxt = sed_pkg::PH_LEN_LO;
              end
            end
          end
          sed_pkg::PH_LEN_LO: begin
            str_left_nxt = {{(LW-8){1'b0}}, in_byte};
            phase_nxt    = sed_pkg::PH_LEN_HI;
          end
          sed_pkg::PH_LEN_HI: begin
            str_left_nxt = len_full;
            if ({1'b0, off_inc} + {2'b0, len_full} > {1'b0, rec_total_r}) begin
              err_hit = 1'b1;
              res_err = sed_pkg::ERR_OVERRUN;
            end else if (len_full == '0) begin
              // empty string ends right here
              str_num_nxt = sn_inc[1:0];
              if (sn_inc[2]) begin
                phase_nxt = sed_pkg::PH_TRAIL;
              end else if ({1'b0, off_inc} + 18'd2 > {1'b0, rec_total_r}) begin
                err_hit = 1'b1;
                res_err = sed_pkg::ERR_OVERRUN;
              end else begin
                phase_nxt = sed_pkg::PH_LEN_LO;
              end
            end else begin
              phase_nxt = sed_pkg::PH_STR;
            end
          end
          sed_pkg::PH_STR: begin
            if (str_num_r == 2'd0) begin
              // cap is name_limit-1 bytes, none when the limit is zero
              emit = ({1'b0, name_sent_r} + 17'd1) < {8'b0, name_limit_r};
              name_sent_nxt = name_sent_r + LW'(1);
            end
            str_left_nxt = left_dec;
            if (left_dec == '0) begin
              str_num_nxt = sn_inc[1:0];
              if (sn_inc[2]) begin
                phase_nxt = sed_pkg::PH_TRAIL;
              end else if ({1'b0, off_inc} + 18'd2 > {1'b0, rec_total_r}) begin
                err_hit = 1'b1;
                res_err = sed_pkg::ERR_OVERRUN;
              end else begin
                phase_nxt = sed_pkg::PH_LEN_LO;
              end
            end
          end
          default: begin
            phase_nxt = sed_pkg::PH_TRAIL;
          end
        endcase

        byte_off_nxt = off_inc;
        done = ~err_hit && (phase_nxt == sed_pkg::PH_TRAIL) && (off_inc >= rec_total_nxt);
        if (~err_hit && ~done && in_last) begin
          err_hit = 1'b1;
          res_err = sed_pkg::ERR_TRUNC;
        end

        if (err_hit) begin
          res_valid   = 1'b1;
          res_kind    = sed_pkg::KIND_BAD;
          clear_rec   = 1'b1;
          discard_nxt = ~in_last;
        end else if (done) begin
          res_valid    = 1'b1;
          res_kind     = sed_pkg::KIND_DONE;
          res_len      = length_nxt;
          res_dir      = mode_dir_nxt | qid_dir_nxt;
          res_consumed = rec_total_nxt;
          clear_rec    = 1'b1;
        end else if (emit) begin
          res_valid = 1'b1;
          res_kind  = sed_pkg::KIND_NAME;
          res_char  = in_byte;
        end
        if (!err_hit) begin
          res_err = sed_pkg::ERR_SHORT;
        end

        if (clear_rec) begin
          phase_nxt     = sed_pkg::PH_SZ_LO;
          byte_off_nxt  = '0;
          rec_total_nxt = '0;
          qid_dir_nxt   = 1'b0;
          mode_dir_nxt  = 1'b0;
          length_nxt    = 64'd0;
          str_left_nxt  = '0;
          str_num_nxt   = '0;
          name_sent_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_limit_r <= sed_pkg::NAME_LIMIT_RST;
      phase_r      <= sed_pkg::PH_SZ_LO;
      byte_off_r   <= '0;
      rec_total_r  <= '0;
      qid_dir_r    <= 1'b0;
      mode_dir_r   <= 1'b0;
      length_r     <= 64'd0;
      str_left_r   <= '0;
      str_num_r    <= '0;
      name_sent_r  <= '0;
      discard_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        name_limit_r <= cfg_wr_data;
      end
      phase_r     <= phase_nxt;
      byte_off_r  <= byte_off_nxt;
      rec_total_r <= rec_total_nxt;
      qid_dir_r   <= qid_dir_nxt;
      mode_dir_r  <= mode_dir_nxt;
      length_r    <= length_nxt;
      str_left_r  <= str_left_nxt;
      str_num_r   <= str_num_nxt;
      name_sent_r <= name_sent_nxt;
      discard_r   <= discard_nxt;
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= res_valid;
      end
    end
  end

  // result register, loaded only when a word goes in (output is free then)
  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      kind_r      <= res_kind;
      name_char_r <= res_char;
      file_len_r  <= res_len;
      is_dir_r    <= res_dir;
      consumed_r  <= res_consumed;
      err_code_r  <= res_err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_name_char   = name_char_r;
  assign out_file_length = file_len_r;
  assign out_dir_flag    = is_dir_r;
  assign out_consumed    = consumed_r;
  assign out_error_code  = err_code_r;

  a_discard_idle: assert property (@(posedge clk) disable iff (!rst_n)
    discard_r |-> phase_r == sed_pkg::PH_SZ_LO)
    else $error("discarding outside the size phase");

  a_done_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == sed_pkg::KIND_DONE |-> consumed_r >= sed_pkg::MIN_TOTAL)
    else $error("completed record shorter than minimum");

  a_str_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == sed_pkg::PH_STR |-> str_left_r != '0)
    else $error("string phase with nothing left");

  a_trail_open: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == sed_pkg::PH_TRAIL |-> byte_off_r < rec_total_r)
    else $error("trailer phase past record end");

  a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && discard_r |=> !out_valid_r)
    else $error("result produced while discarding");

endmodule

// ===== bench/stat_entry_decoder_test.sv =====
// stat_entry_decoder_test: self-checking bench for the 9P stat record decoder
// builds record streams byte by byte, predicts every result word and compares them
// depends on sed_pkg and the stat_entry_decoder rtl

typedef struct packed {
  logic [1:0]                kind;
  logic [7:0]                name_char;
  logic [63:0]               file_length;
  logic                      is_dir;
  logic [sed_pkg::OFF_W-1:0] consumed;
  logic [1:0]                error_code;
} stat_result_t;

class stat_record_scoreboard;
  localparam int MODE_FIRST = int'(sed_pkg::OFF_MODE_TOP) - 3;
  localparam int unsigned OW = sed_pkg::OFF_W;
  localparam int unsigned LW = sed_pkg::LEN_W;

  stat_result_t     expected_q[$];
  int unsigned      mismatches;
  int unsigned      names_seen;
  int unsigned      records_done;
  int unsigned      records_bad;

  logic [sed_pkg::LIM_W-1:0] name_limit;
  logic [2:0]       phase;
  logic [OW-1:0]    byte_offset;
  logic [OW-1:0]    record_total;
  logic [7:0]       qid_kind;
  logic [31:0]      mode_word;
  logic [63:0]      length_word;
  logic [LW-1:0]    string_left;
  int               string_number;
  logic [LW-1:0]    name_sent;
  bit               discarding;

  function new();
    name_limit   = sed_pkg::NAME_LIMIT_RST;
    discarding   = 1'b0;
    mismatches   = 0;
    names_seen   = 0;
    records_done = 0;
    records_bad  = 0;
    clear_record();
  endfunction

  function void clear_record();
    phase         = sed_pkg::PH_SZ_LO;
    byte_offset   = '0;
    record_total  = '0;
    qid_kind      = '0;
    mode_word     = '0;
    length_word   = '0;
    string_left   = '0;
    string_number = 0;
    name_sent     = '0;
  endfunction

  function void set_limit(logic [sed_pkg::LIM_W-1:0] v);
    name_limit = v;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // a string just ended; next_off is the offset of the following byte
  function int close_string(int next_off);
    string_number = string_number + 1;
    if (string_number >= 4) begin
      phase = sed_pkg::PH_TRAIL;
      return -1;
    end
    if (next_off + 2 > int'(record_total)) return int'(sed_pkg::ERR_OVERRUN);
    phase = sed_pkg::PH_LEN_LO;
    return -1;
  endfunction

  function bit decode_byte(logic [7:0] b, bit last, output stat_result_t r);
    int o;
    int err;
    bit done;
    bit emit;
    o    = int'(byte_offset);
    err  = -1;
    done = 1'b0;
    emit = 1'b0;
    r    = '0;
    if (discarding) begin
      if (last) begin
        discarding = 1'b0;
        clear_record();
      end
      return 1'b0;
    end
    case (phase)
      sed_pkg::PH_SZ_LO: begin
        clear_record();
        record_total = OW'(b);
        o = 0;
        phase = sed_pkg::PH_SZ_HI;
        if (last) err = int'(sed_pkg::ERR_SHORT);
      end
      sed_pkg::PH_SZ_HI: begin
        record_total = OW'({b, record_total[7:0]}) + OW'(2);
        phase = sed_pkg::PH_FIXED;
        if (record_total < sed_pkg::MIN_TOTAL) err = int'(sed_pkg::ERR_SIZE);
      end
      sed_pkg::PH_FIXED: begin
        if (o == int'(sed_pkg::OFF_QID_TYPE)) qid_kind = b;
        else if (o >= MODE_FIRST && o <= int'(sed_pkg::OFF_MODE_TOP))
          mode_word |= 32'(b) << (8 * (o - MODE_FIRST));
        else if (o >= int'(sed_pkg::OFF_LENGTH) && o < int'(sed_pkg::OFF_FIXED_END))
          length_word |= 64'(b) << (8 * (o - int'(sed_pkg::OFF_LENGTH)));
        if (o + 1 >= int'(sed_pkg::OFF_FIXED_END)) begin
          string_number = 0;
          if (o + 3 > int'(record_total)) err = int'(sed_pkg::ERR_OVERRUN);
          else phase = sed_pkg::PH_LEN_LO;
        end
      end
      sed_pkg::PH_LEN_LO: begin
        string_left = LW'(b);
        phase = sed_pkg::PH_LEN_HI;
      end
      sed_pkg::PH_LEN_HI: begin
        string_left = {b, string_left[7:0]};
        if (o + 1 + int'(string_left) > int'(record_total))
          err = int'(sed_pkg::ERR_OVERRUN);
        else if (string_left == 0) err = close_string(o + 1);
        else phase = sed_pkg::PH_STR;
      end
      sed_pkg::PH_STR: begin
        if (string_number == 0) begin
          if (name_limit != 0 && int'(name_sent) < int'(name_limit) - 1) emit = 1'b1;
          name_sent = name_sent + 1'b1;
        end
        string_left = string_left - 1'b1;
        if (string_left == 0) err = close_string(o + 1);
      end
      default: phase = sed_pkg::PH_TRAIL;
    endcase

    byte_offset = OW'(o + 1);
    if (err < 0 && phase == sed_pkg::PH_TRAIL && byte_offset >= record_total) done = 1'b1;
    if (err < 0 && !done && last) err = int'(sed_pkg::ERR_TRUNC);

    // an error beats both completion and a pending name byte
    if (err >= 0) begin
      r.kind       = sed_pkg::KIND_BAD;
      r.error_code = 2'(err);
      clear_record();
      discarding = !last;
      return 1'b1;
    end
    if (done) begin
      r.kind        = sed_pkg::KIND_DONE;
      r.file_length = length_word;
      r.is_dir      = mode_word[31] | qid_kind[7];
      r.consumed    = record_total;
      clear_record();
      return 1'b1;
    end
    if (emit) begin
      r.kind      = sed_pkg::KIND_NAME;
      r.name_char = b;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void note_input(logic [7:0] b, bit last);
    stat_result_t r;
    if (decode_byte(b, last, r)) expected_q.push_back(r);
  endfunction

  function void report(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endfunction

  function void check_result(stat_result_t got);
    stat_result_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      $display("%0t: result word with none expected, expected none, actual kind %0d",
               $time, got.kind);
      return;
    end
    want = expected_q.pop_front();
    case (want.kind)
      sed_pkg::KIND_NAME: names_seen++;
      sed_pkg::KIND_DONE: records_done++;
      default:            records_bad++;
    endcase
    if (got.kind !== want.kind) report("kind", want.kind, got.kind);
    if (got.name_char !== want.name_char) report("name_char", want.name_char, got.name_char);
    if (got.file_length !== want.file_length)
      report("file_length", want.file_length, got.file_length);
    if (got.is_dir !== want.is_dir) report("is_dir", want.is_dir, got.is_dir);
    if (got.consumed !== want.consumed) report("consumed", want.consumed, got.consumed);
    if (got.error_code !== want.error_code)
      report("error_code", want.error_code, got.error_code);
  endfunction
endclass

module stat_entry_decoder_test;
  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [sed_pkg::LIM_W-1:0]  cfg_wr_data;
  logic                       in_valid;
  logic                       in_stall;
  logic [7:0]                 in_byte;
  logic                       in_last;
  logic                       out_valid;
  logic                       out_stall;
  logic [1:0]                 out_kind;
  logic [7:0]                 out_name_char;
  logic [63:0]                out_file_length;
  logic                       out_dir_flag;
  logic [sed_pkg::OFF_W-1:0]  out_consumed;
  logic [1:0]                 out_error_code;

  stat_record_scoreboard sb;
  bit [8:0]            stream_q[$];   // {last, byte}
  bit                  in_burst;
  bit                  out_burst;
  bit                  ended_on_last;
  int unsigned         sent_bytes;
  int unsigned         records_sent;
  int unsigned         settings_used;
  logic [sed_pkg::LIM_W-1:0] limits [3];

  stat_entry_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_name_char   (out_name_char),
    .out_file_length (out_file_length),
    .out_dir_flag    (out_dir_flag),
    .out_consumed    (out_consumed),
    .out_error_code  (out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin : in_mon
    if (rst_n && in_valid && !in_stall) sb.note_input(in_byte, in_last);
  end

  always @(posedge clk) begin : out_mon
    stat_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_kind, out_name_char, out_file_length, out_dir_flag, out_consumed,
             out_error_code};
      sb.check_result(got);
    end
  end

  initial begin : out_side
    int hold;
    out_stall <= 1'b0;
    forever begin
      hold = pick_gap(out_burst);
      @(posedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
  end

  task automatic send_byte(logic [7:0] b, bit last);
    int gap;
    gap = pick_gap(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_stream();
    bit [8:0] w;
    while (stream_q.size() > 0) begin
      w = stream_q.pop_front();
      send_byte(w[7:0], w[8]);
      ended_on_last = w[8];
    end
  endtask

  function automatic void push_byte(logic [7:0] b);
    stream_q.push_back({1'b0, b});
  endfunction

  function automatic void push_random(int n);
    repeat (n) push_byte(8'($urandom));
  endfunction

  function automatic void push_le16(logic [15:0] v);
    push_byte(v[7:0]);
    push_byte(v[15:8]);
  endfunction

  function automatic void push_string(int len);
    push_le16(16'(len));
    push_random(len);
  endfunction

  function automatic void mark_last();
    stream_q[stream_q.size()-1] = stream_q[stream_q.size()-1] | 9'h100;
  endfunction

  function automatic void build_record(int name_len, int uid_len, int gid_len, int muid_len,
                                       int trail, logic [7:0] qtype, logic [31:0] mode,
                                       logic [63:0] flen, int size_adjust);
    int total;
    int k;
    total = 49 + name_len + uid_len + gid_len + muid_len + trail;
    push_le16(16'(total - 2 + size_adjust));
    push_random(6);           // type, dev
    push_byte(qtype);
    push_random(12);          // qid version, path
    for (k = 0; k < 4; k++) push_byte(mode[8*k +: 8]);
    push_random(8);           // atime, mtime
    for (k = 0; k < 8; k++) push_byte(flen[8*k +: 8]);
    push_string(name_len);
    push_string(uid_len);
    push_string(gid_len);
    push_string(muid_len);
    push_random(trail);
    records_sent++;
  endfunction

  // hold off the sender until every result is out and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [sed_pkg::LIM_W-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_limit(v);
    settings_used++;
  endtask

  task automatic random_record();
    int pick;
    int sel;
    int name_len;
    int idx;
    int cut;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 39);
    if (sel < 4) name_len = $urandom_range(0, 20);
    else name_len = $urandom_range(0, 6);
    if (pick < 88) begin
      build_record(name_len, $urandom_range(0, 4), $urandom_range(0, 4),
                   $urandom_range(0, 4), $urandom_range(0, 4), 8'($urandom), $urandom,
                   {$urandom, $urandom}, (pick >= 80) ? -int'($urandom_range(1, 12)) : 0);
      if (pick < 60) begin
        // well formed; half of them share the buffer with the next record
        if ($urandom_range(0, 1) == 1) mark_last();
      end else if (pick < 70) begin
        idx = $urandom_range(0, stream_q.size() - 1);
        stream_q[idx] = {1'b0, 8'($urandom)};
        mark_last();
      end else if (pick < 80) begin
        cut = $urandom_range(1, stream_q.size());
        while (stream_q.size() > cut) void'(stream_q.pop_back());
        mark_last();
      end else begin
        mark_last();
      end
    end else if (pick < 95) begin
      // undersized record followed by junk
      push_le16(16'($urandom_range(0, 44)));
      push_random($urandom_range(0, 10));
      mark_last();
      records_sent++;
    end else begin
      push_random($urandom_range(1, 20));
      mark_last();
      records_sent++;
    end
    send_stream();
  endtask

  initial begin : stimulus
    sb = new();
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_byte     <= '0;
    in_last     <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_burst      = 1'b0;
    out_burst     = 1'b0;
    ended_on_last = 1'b1;
    sent_bytes    = 0;
    records_sent  = 0;
    settings_used = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // two back-to-back records in one buffer: qid dir bit, then mode dir bit
    build_record(3, 1, 0, 2, 1, 8'h80, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    build_record(2, 0, 0, 0, 0, 8'h7F, 32'h8000_0000, 64'h0123_4567_89AB_CDEF, 0);
    mark_last();
    send_stream();
    // buffer ends on the first size byte
    push_byte(8'h31);
    mark_last();
    send_stream();
    // undersized, then discard to the end of the buffer
    push_le16(16'd44);
    push_random(3);
    mark_last();
    send_stream();
    // undersized on a last byte
    push_le16(16'd0);
    mark_last();
    send_stream();
    // total of 47: room for only three string lengths
    build_record(0, 0, 0, 0, 0, 8'h00, 32'h0, 64'h0, -2);
    void'(stream_q.pop_back());
    void'(stream_q.pop_back());
    mark_last();
    send_stream();
    // name length runs past the record on the last byte of the buffer
    build_record(3, 0, 0, 0, 0, 8'h00, 32'h0, 64'h0, 0);
    stream_q[42] = 9'h001;
    while (stream_q.size() > 43) void'(stream_q.pop_back());
    mark_last();
    send_stream();
    // buffer ends inside the fixed part
    build_record(0, 0, 0, 0, 0, 8'h00, 32'h0, 64'h0, 0);
    while (stream_q.size() > 20) void'(stream_q.pop_back());
    mark_last();
    send_stream();
    // buffer ends on a name byte: error wins, name byte dropped
    build_record(6, 0, 0, 0, 0, 8'h00, 32'h0, 64'h0, 0);
    while (stream_q.size() > 45) void'(stream_q.pop_back());
    mark_last();
    send_stream();
    // largest size field, cut short
    push_le16(16'hFFFF);
    push_random(10);
    mark_last();
    send_stream();

    limits[0] = 9'd0;
    limits[1] = 9'($urandom_range(1, 4));
    limits[2] = 9'd64;
    for (int p = 0; p < 3; p++) begin
      write_limit(limits[p]);
      in_burst  = (p == 1);
      out_burst = (p == 2);
      do begin
        random_record();
      end while (sent_bytes < 300 + 40 * p);
      // close the buffer so the block is back at a size field
      if (!ended_on_last) begin
        push_byte(8'h00);
        mark_last();
        send_stream();
      end
    end
    in_burst  = 1'b0;
    out_burst = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    $display("covered %0d bytes in %0d records under %0d name cap settings",
             sent_bytes, records_sent, settings_used);
    $display("checked %0d name bytes, %0d complete records, %0d rejected records",
             sb.names_seen, sb.records_done, sb.records_bad);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
